// ===== hdl/fcf_pkg.sv =====
// ----------------------------------------------------------------------------
// fcf_pkg: shared types and constants
// Widths, register indexes and the control struct of the FIR convolution block.
// ----------------------------------------------------------------------------
package fcf_pkg;

  localparam int MAX_TAPS_DEF = 8;   // default tap count ceiling (2..8)
  localparam int SAMPLE_W     = 16;
  localparam int TAP_W        = 16;
  localparam int PROD_W       = SAMPLE_W + TAP_W;
  localparam int ACC_W        = 35;
  localparam int CFG_W        = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int TAP_COUNT_W  = 4;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 40;
  localparam int FIFO_DEPTH   = 4;   // output queue entries, also the credit limit

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAPS_LOW  = 2'd0,
    CFG_TAPS_HIGH = 2'd1,
    CFG_TAP_COUNT = 2'd2
  } cfg_reg_t;

  // Control that travels with one beat down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } beat_ctl_t;

endpackage

// ===== hdl/fcf_seq.sv =====
// ----------------------------------------------------------------------------
// fcf_seq: delay line and tail sequencer
// Builds the sample window for each beat and shifts zeros in after a last sample.
// ----------------------------------------------------------------------------
module fcf_seq #(
  parameter int MAX_TAPS = fcf_pkg::MAX_TAPS_DEF,
  parameter int NW       = $clog2(MAX_TAPS + 1)
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      accept,
  input  logic [fcf_pkg::SAMPLE_W-1:0]              sample,
  input  logic                                      last_sample,
  input  logic [NW-1:0]                             ntaps,
  input  logic                                      room,
  output logic                                      in_ready,
  output logic                                      issue,
  output fcf_pkg::beat_ctl_t                        ctl,
  output logic [MAX_TAPS-1:0][fcf_pkg::SAMPLE_W-1:0] window
);

  localparam int CW = $clog2(MAX_TAPS);

  logic [MAX_TAPS-2:0][fcf_pkg::SAMPLE_W-1:0] delay;
  logic                                       tail_active;
  logic [CW-1:0]                              tail_left;
  logic [fcf_pkg::SAMPLE_W-1:0]               x_in;
  logic                                       is_final;

  assign in_ready = room && !tail_active;
  assign issue    = accept || (tail_active && room);
  assign x_in     = accept ? sample : '0;
  assign is_final = accept ? (last_sample && (ntaps == NW'(1)))
                           : (tail_left == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      delay       <= '0;
      tail_active <= 1'b0;
      tail_left   <= '0;
      ctl         <= '0;
    end else begin
      ctl.valid <= issue;
      ctl.last  <= issue && is_final;
      if (issue) begin
        if (is_final) begin
          delay <= '0;
        end else begin
          for (int k = MAX_TAPS - 2; k > 0; k--) begin
            delay[k] <= delay[k-1];
          end
          delay[0] <= x_in;
        end
      end
      if (accept) begin
        if (last_sample && (ntaps != NW'(1))) begin
          tail_active <= 1'b1;
          tail_left   <= CW'(ntaps - NW'(1));
        end
      end else if (issue) begin
        tail_left <= tail_left - CW'(1);
        if (is_final) begin
          tail_active <= 1'b0;
        end
      end
    end
  end

  // window is payload: newest sample in slot 0
  always_ff @(posedge clk) begin
    if (issue) begin
      window[0] <= x_in;
      for (int k = 1; k < MAX_TAPS; k++) begin
        window[k] <= delay[k-1];
      end
    end
  end

endmodule

// ===== hdl/fcf_mac.sv =====
// ----------------------------------------------------------------------------
// fcf_mac: parallel multiply and sum
// One registered product per tap, then the 35-bit sum over the taps in use.
// ----------------------------------------------------------------------------
module fcf_mac #(
  parameter int MAX_TAPS = fcf_pkg::MAX_TAPS_DEF,
  parameter int NW       = $clog2(MAX_TAPS + 1)
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  fcf_pkg::beat_ctl_t                         ctl,
  input  logic [MAX_TAPS-1:0][fcf_pkg::SAMPLE_W-1:0] window,
  input  logic [MAX_TAPS-1:0][fcf_pkg::TAP_W-1:0]    taps,
  input  logic [NW-1:0]                              ntaps,
  output fcf_pkg::beat_ctl_t                         res_ctl,
  output logic signed [fcf_pkg::ACC_W-1:0]           res_value
);

  logic signed [fcf_pkg::PROD_W-1:0] prod [MAX_TAPS];
  logic        [fcf_pkg::TAP_W-1:0]  tap_used [MAX_TAPS];

  // taps beyond the count contribute nothing
  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      tap_used[k] = (ntaps > NW'(k)) ? taps[k] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_ctl <= '0;
    end else begin
      res_ctl <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        prod[k] <= $signed(window[k]) * $signed(tap_used[k]);
      end
    end
  end

  always_comb begin
    res_value = '0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      res_value = res_value + fcf_pkg::ACC_W'(prod[k]);
    end
  end

endmodule

// ===== hdl/fcf_fifo.sv =====
// ----------------------------------------------------------------------------
// fcf_fifo: output queue
// Small register queue that holds finished results until the sink takes them.
// ----------------------------------------------------------------------------
module fcf_fifo #(
  parameter int WIDTH = fcf_pkg::ACC_W + 1,
  parameter int DEPTH = fcf_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic             not_empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign rdata     = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      count <= count + CNT_W'(wr) - CNT_W'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ===== hdl/fir_convolution_full.sv =====
// ----------------------------------------------------------------------------
// fir_convolution_full: direct-form FIR, full linear convolution
// Up to MAX_TAPS signed 16-bit taps, exact 35-bit outputs, zero-filled tail.
// ----------------------------------------------------------------------------
// Path: fcf_seq registers the window, fcf_mac registers the products, then the sum enters the queue.
// Throughput: one sample per cycle. A sample with tlast high also issues
//   N-1 tail beats (N = taps in use), one per cycle, with s_axis_tready low.
// Credit of FIFO_DEPTH beats in flight sets the pace under output stalls.
// Reset (rst, synchronous): delay line zero, taps zero, tap count 1, queue empty.
// ----------------------------------------------------------------------------
module fir_convolution_full #(
  parameter int MAX_TAPS = fcf_pkg::MAX_TAPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fcf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [15:0] sample
  input  logic                              s_axis_tlast,   // last_sample
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fcf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [34:0] filtered_value, zero pad
  output logic                              m_axis_tlast,   // last_output
  // configuration writes
  input  logic                              cfg_we,
  input  logic [fcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fcf_pkg::CFG_W-1:0]         cfg_data
);

  localparam int NW    = $clog2(MAX_TAPS + 1);
  localparam int PEND_W = $clog2(fcf_pkg::FIFO_DEPTH + 1);

  // configuration registers
  logic [fcf_pkg::CFG_W-1:0]       taps_low;
  logic [fcf_pkg::CFG_W-1:0]       taps_high;
  logic [fcf_pkg::TAP_COUNT_W-1:0] tap_count;

  logic [2*fcf_pkg::CFG_W-1:0]              taps_all;
  logic [MAX_TAPS-1:0][fcf_pkg::TAP_W-1:0]  taps;
  logic [NW-1:0]                            ntaps;

  // pipeline
  logic                                       in_fire;
  logic                                       out_fire;
  logic                                       issue;
  logic                                       in_ready;
  logic                                       room;
  logic [PEND_W-1:0]                          pending;
  fcf_pkg::beat_ctl_t                         win_ctl;
  logic [MAX_TAPS-1:0][fcf_pkg::SAMPLE_W-1:0] window;
  fcf_pkg::beat_ctl_t                         res_ctl;
  logic signed [fcf_pkg::ACC_W-1:0]           res_value;
  logic [fcf_pkg::ACC_W:0]                    q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_low  <= '0;
      taps_high <= '0;
      tap_count <= fcf_pkg::TAP_COUNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcf_pkg::CFG_TAPS_LOW:  taps_low  <= cfg_data;
        fcf_pkg::CFG_TAPS_HIGH: taps_high <= cfg_data;
        fcf_pkg::CFG_TAP_COUNT: tap_count <= cfg_data[fcf_pkg::TAP_COUNT_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // tap k sits at bits 16k+15:16k of the joined pair
  assign taps_all = {taps_high, taps_low};
  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      taps[k] = taps_all[k*fcf_pkg::TAP_W +: fcf_pkg::TAP_W];
    end
  end

  // zero counts as one tap, anything above the ceiling saturates
  always_comb begin
    if (tap_count == '0) begin
      ntaps = NW'(1);
    end else if (tap_count > fcf_pkg::TAP_COUNT_W'(MAX_TAPS)) begin
      ntaps = NW'(MAX_TAPS);
    end else begin
      ntaps = NW'(tap_count);
    end
  end

  // credit: beats in the pipeline plus beats in the queue never exceed its depth,
  // so the queue cannot overflow and ready depends on registers only
  assign room          = (pending < PEND_W'(fcf_pkg::FIFO_DEPTH));
  assign s_axis_tready = in_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PEND_W'(issue) - PEND_W'(out_fire);
    end
  end

  fcf_seq #(
    .MAX_TAPS (MAX_TAPS),
    .NW       (NW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_fire),
    .sample      (s_axis_tdata[fcf_pkg::SAMPLE_W-1:0]),
    .last_sample (s_axis_tlast),
    .ntaps       (ntaps),
    .room        (room),
    .in_ready    (in_ready),
    .issue       (issue),
    .ctl         (win_ctl),
    .window      (window)
  );

  fcf_mac #(
    .MAX_TAPS (MAX_TAPS),
    .NW       (NW)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (win_ctl),
    .window    (window),
    .taps      (taps),
    .ntaps     (ntaps),
    .res_ctl   (res_ctl),
    .res_value (res_value)
  );

  fcf_fifo #(
    .WIDTH (fcf_pkg::ACC_W + 1),
    .DEPTH (fcf_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (res_ctl.valid),
    .wdata     ({res_ctl.last, res_value}),
    .rd        (out_fire),
    .not_empty (m_axis_tvalid),
    .rdata     (q_rdata)
  );

  assign m_axis_tdata = {{(fcf_pkg::OUT_TDATA_W - fcf_pkg::ACC_W){1'b0}},
                         q_rdata[fcf_pkg::ACC_W-1:0]};
  assign m_axis_tlast = q_rdata[fcf_pkg::ACC_W];

endmodule

// ===== tb/fir_convolution_full_tb.sv =====
// ----------------------------------------------------------------------------
// fir_convolution_full_tb: self-checking bench for the full-convolution FIR
// Drives sample sequences under random stalls on both streams, predicts every
// output beat (value and tlast) with its own tap/delay-line model, and checks
// each beat against the oldest pending prediction.
// ----------------------------------------------------------------------------
module fir_convolution_full_tb;

  localparam int MAX_TAPS = fcf_pkg::MAX_TAPS_DEF;
  localparam int CYCLE_LIMIT = 200_000;  // far above the slowest legal run
  localparam int MAX_REPORTS = 100;      // cap on printed mismatch lines
  localparam int END_SETTLE = 8;         // cycles watched for stray beats at the end

  // index 3 maps to no register; writes there must be dropped
  localparam logic [fcf_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam logic [fcf_pkg::SAMPLE_W-1:0] FULL_POS = 16'h7FFF;
  localparam logic [fcf_pkg::SAMPLE_W-1:0] FULL_NEG = 16'h8000;

  // one predicted output beat
  typedef struct packed {
    logic [fcf_pkg::ACC_W-1:0] value;
    logic                      last;
  } filtered_t;

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [fcf_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] sample
  logic                            s_axis_tlast;   // last_sample
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [fcf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // [34:0] filtered_value, [39:35] zero
  logic                            m_axis_tlast;   // last_output
  logic                            cfg_we;
  logic [fcf_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [fcf_pkg::CFG_W-1:0]       cfg_data;

  fir_convolution_full dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and the delay line
  // --------------------------------------------------------------------------
  logic [fcf_pkg::CFG_W-1:0]           taps_lo_m;
  logic [fcf_pkg::CFG_W-1:0]           taps_hi_m;
  logic [fcf_pkg::TAP_COUNT_W-1:0]     tap_cnt_m;
  logic signed [fcf_pkg::SAMPLE_W-1:0] history [MAX_TAPS-2:0];  // [0] = newest past sample

  filtered_t filtered_due[$];   // predicted beats not yet seen on the output

  int mismatch_count = 0;
  int cycle_count = 0;
  int tx_idle_pct;              // chance in 100 that the sender skips a cycle
  int rx_stall_pct;             // chance in 100 that the receiver holds tready low

  // --------------------------------------------------------------------------
  // Clock and cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d beats still pending",
             cycle_count, filtered_due.size());
    $display("fir_convolution_full: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: tready changes on the falling edge, random stalls
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic signed [fcf_pkg::TAP_W-1:0] tap_at(input int k);
    logic [fcf_pkg::CFG_W-1:0] word;
    word = (k < 4) ? taps_lo_m : taps_hi_m;
    return word[(k % 4)*fcf_pkg::TAP_W +: fcf_pkg::TAP_W];
  endfunction

  // one MAC pass over the taps in use, then shift x into the delay line
  function automatic logic [fcf_pkg::ACC_W-1:0] fir_tick(
      input logic signed [fcf_pkg::SAMPLE_W-1:0] x, input int n);
    longint acc;
    acc = longint'(tap_at(0)) * longint'(x);
    for (int k = 1; k < n; k++)
      acc += longint'(tap_at(k)) * longint'(history[k-1]);
    for (int k = MAX_TAPS - 2; k > 0; k--)
      history[k] = history[k-1];
    history[0] = x;
    return acc[fcf_pkg::ACC_W-1:0];
  endfunction

  // all beats caused by one accepted sample; a marked sample adds the
  // zero-fed tail and then empties the delay line
  task automatic convolve_sample(input logic [fcf_pkg::SAMPLE_W-1:0] smp, input logic lst);
    int n;
    filtered_t b;
    n = int'(tap_cnt_m);
    if (n < 1) n = 1;                 // count 0 acts as a single tap
    if (n > MAX_TAPS) n = MAX_TAPS;   // counts above the ceiling saturate
    b.value = fir_tick($signed(smp), n);
    b.last = lst && (n == 1);
    filtered_due.push_back(b);
    if (lst) begin
      for (int i = 1; i < n; i++) begin
        b.value = fir_tick('0, n);
        b.last = (i == n - 1);
        filtered_due.push_back(b);
      end
      foreach (history[i]) history[i] = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Output check, sampled at the rising edge
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0d] MISMATCH: %s", cycle_count, what);
  endtask

  always @(posedge clk) begin : check_outputs
    filtered_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (filtered_due.size() == 0) begin
        report_mismatch($sformatf("beat with nothing pending, tdata=%h tlast=%b",
                                  m_axis_tdata, m_axis_tlast));
      end else begin
        want = filtered_due.pop_front();
        if (m_axis_tdata[fcf_pkg::ACC_W-1:0] !== want.value)
          report_mismatch($sformatf("filtered_value %0d, expected %0d",
                                    $signed(m_axis_tdata[fcf_pkg::ACC_W-1:0]),
                                    $signed(want.value)));
        if (m_axis_tdata[fcf_pkg::OUT_TDATA_W-1:fcf_pkg::ACC_W] !== '0)
          report_mismatch($sformatf("tdata pad bits %b, expected zero",
                                    m_axis_tdata[fcf_pkg::OUT_TDATA_W-1:fcf_pkg::ACC_W]));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast, want.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge
  // --------------------------------------------------------------------------
  task automatic set_idle_mix(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // One sample beat; tvalid stays high on return so back-to-back beats
  // never drop it between them.
  task automatic send_sample(input logic [fcf_pkg::SAMPLE_W-1:0] smp, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    convolve_sample(smp, lst);
  endtask

  // stop sending and hold off until every predicted beat has come out
  task automatic wait_for_outputs();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (filtered_due.size() != 0) @(posedge clk);
  endtask

  // register write; only called with the block drained
  task automatic write_reg(input logic [fcf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fcf_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      fcf_pkg::CFG_TAPS_LOW:  taps_lo_m = data;
      fcf_pkg::CFG_TAPS_HIGH: taps_hi_m = data;
      fcf_pkg::CFG_TAP_COUNT: tap_cnt_m = data[fcf_pkg::TAP_COUNT_W-1:0];
      default: ;                      // unmapped index: dropped
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random values, biased toward full scale
  // --------------------------------------------------------------------------
  function automatic logic [fcf_pkg::TAP_W-1:0] random_tap();
    case ($urandom_range(7))
      0: return FULL_POS;
      1: return FULL_NEG;
      2: return '0;
      3: return fcf_pkg::TAP_W'($urandom_range(16) - 8);
      default: return fcf_pkg::TAP_W'($urandom);
    endcase
  endfunction

  function automatic logic [fcf_pkg::SAMPLE_W-1:0] random_sample();
    case ($urandom_range(9))
      0: return FULL_POS;
      1: return FULL_NEG;
      2: return '0;
      default: return fcf_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // tap count word: usually 1..8, sometimes 0 or above the ceiling,
  // upper bits always junk (the block keeps only the low nibble)
  function automatic logic [fcf_pkg::CFG_W-1:0] random_count_word();
    logic [fcf_pkg::CFG_W-1:0] w;
    w = {$urandom, $urandom};
    w[fcf_pkg::TAP_COUNT_W-1:0] = ($urandom_range(5) == 0)
                                  ? fcf_pkg::TAP_COUNT_W'($urandom_range(15))
                                  : fcf_pkg::TAP_COUNT_W'($urandom_range(1, 8));
    return w;
  endfunction

  task automatic load_random_config();
    write_reg(fcf_pkg::CFG_TAPS_LOW,  {random_tap(), random_tap(), random_tap(), random_tap()});
    write_reg(fcf_pkg::CFG_TAPS_HIGH, {random_tap(), random_tap(), random_tap(), random_tap()});
    if ($urandom_range(2) != 0)
      write_reg(fcf_pkg::CFG_TAP_COUNT, random_count_word());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: taps zero, one tap -> every beat zero, tlast on the marked one
  task automatic test_reset_defaults();
    send_sample(FULL_POS, 1'b0);
    send_sample(FULL_NEG, 1'b0);
    send_sample(16'h0001, 1'b1);
  endtask

  // All taps and samples at the negative full scale: largest positive sum
  task automatic test_full_scale_sums();
    wait_for_outputs();
    write_reg(fcf_pkg::CFG_TAPS_LOW,  {4{FULL_NEG}});
    write_reg(fcf_pkg::CFG_TAPS_HIGH, {4{FULL_NEG}});
    write_reg(fcf_pkg::CFG_TAP_COUNT, fcf_pkg::CFG_W'(MAX_TAPS));
    for (int i = 0; i < MAX_TAPS; i++)
      send_sample(FULL_NEG, i == MAX_TAPS - 1);
  endtask

  // Impulse reads the taps back one by one; full-scale impulses of both signs
  // hit the most negative products
  task automatic test_impulse_response();
    wait_for_outputs();
    write_reg(fcf_pkg::CFG_TAPS_LOW,  {16'hFFFF, 16'h0001, FULL_NEG, FULL_POS});
    write_reg(fcf_pkg::CFG_TAPS_HIGH, {FULL_POS, 16'h0000, 16'hEDCB, 16'h1234});
    send_sample(16'h0001, 1'b1);
    send_sample(FULL_NEG, 1'b1);
    send_sample(FULL_POS, 1'b1);
  endtask

  // Tap count zero and above the ceiling, junk upper bits, the unmapped
  // index, and short counts with and without a marked sample
  task automatic test_tap_count_limits();
    wait_for_outputs();
    write_reg(fcf_pkg::CFG_TAP_COUNT, {60'hABCDE12345678F0, 4'h0});
    send_sample(FULL_POS, 1'b1);
    wait_for_outputs();
    write_reg(fcf_pkg::CFG_TAP_COUNT, {60'h5A5A5A5A5A5A5A5, 4'hF});
    send_sample(16'h0001, 1'b1);
    wait_for_outputs();
    write_reg(fcf_pkg::CFG_TAP_COUNT, fcf_pkg::CFG_W'(5));
    write_reg(CFG_IDX_SPARE, {fcf_pkg::CFG_W{1'b1}});
    send_sample(16'h4000, 1'b0);
    send_sample(16'hC000, 1'b1);
    wait_for_outputs();
    write_reg(fcf_pkg::CFG_TAP_COUNT, fcf_pkg::CFG_W'(1));
    send_sample(16'h1111, 1'b0);
    send_sample(16'hEEEE, 1'b1);
  endtask

  // Random sequences in three idle mixes; config is reloaded now and then
  // between sequences, sometimes with an unmarked sequence still open so the
  // delay line carries over into the new setting.
  task automatic test_random_stream(input int n_items);
    int sent;
    int seq_len;
    sent = 0;
    for (int seg = 0; seg < 3; seg++) begin
      wait_for_outputs();
      case (seg)
        0: set_idle_mix(7, 88);
        1: set_idle_mix(88, 7);
        default: set_idle_mix(0, 0);
      endcase
      load_random_config();
      while (sent < n_items * (seg + 1) / 3) begin
        if ($urandom_range(3) == 0) begin
          wait_for_outputs();
          load_random_config();
        end
        seq_len = ($urandom_range(7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
        for (int i = 0; i < seq_len; i++) begin
          send_sample(random_sample(), (i == seq_len - 1) && ($urandom_range(5) != 0));
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = fcf_pkg::CFG_TAPS_LOW;
    cfg_data      = '0;
    taps_lo_m     = '0;
    taps_hi_m     = '0;
    tap_cnt_m     = fcf_pkg::TAP_COUNT_W'(1);
    foreach (history[i]) history[i] = '0;
    set_idle_mix(7, 88);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_full_scale_sums();
    test_impulse_response();
    test_tap_count_limits();
    test_random_stream(90);

    // drain, then watch a few more cycles for beats nobody asked for
    wait_for_outputs();
    repeat (END_SETTLE) @(posedge clk);
    if (filtered_due.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", filtered_due.size()));

    if (mismatch_count == 0)
      $display("fir_convolution_full: match");
    else
      $display("fir_convolution_full: mismatch");
    $finish;
  end

endmodule
